### hdl/ms_pkg.sv
// Shared types for the merge sorter: controller commands, datapath status
// and the element width. No dependencies.
`timescale 1ns / 1ps

package ms_pkg;

    localparam int DATA_W = 32;

    // the controller raises the commands of its state; a merge write may
    // also carry a run or pass advance, and the final output a clear
    typedef struct packed {
        logic load;       // store an incoming element
        logic sort_init;  // width 1, first run, source is the load store
        logic run_init;   // set up bounds and pointers of the next run
        logic step;       // write one merged element, advance pointers
        logic next_run;   // advance to the next pair of runs
        logic next_pass;  // double the width, swap source and destination
        logic emit_init;  // rewind the read pointer for output
        logic emit_adv;   // present one sorted element, advance
        logic clear;      // drop the element count
    } t_ms_cmd;

    typedef struct packed {
        logic n_gt1;      // more than one element held
        logic run_last;   // this step writes the final element of the run
        logic pass_last;  // the current run pair closes the pass
        logic sort_last;  // the current pass is the final one
        logic emit_last;  // the element being emitted is the final one
    } t_ms_stat;

endpackage

### hdl/ms_dp.sv
// Merge sorter datapath: two element stores used in ping-pong, merge
// pointers, run bounds and element count. Depends on ms_pkg.
`timescale 1ns / 1ps

module ms_dp import ms_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_ms_cmd                  i_cmd,
    output t_ms_stat                 o_stat,
    input  logic signed [DATA_W-1:0] i_value,
    output logic signed [DATA_W-1:0] o_sorted_value,
    output logic                     o_final_res
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = CW + 2;

    logic signed [DATA_W-1:0] r_mem0 [DEPTH];
    logic signed [DATA_W-1:0] r_mem1 [DEPTH];

    logic [CW-1:0] r_count, r_width, r_lo, r_mid, r_hi, r_a, r_b, r_k;
    logic          r_src;
    logic signed [DATA_W-1:0] r_q00, r_q01, r_q10, r_q11;

    logic [IW-1:0] n_lo_w, n_lo_2w, n_2w, n_nw;
    logic [CW-1:0] n_mid, n_hi;
    logic signed [DATA_W-1:0] n_qa, n_qb, n_merged;
    logic          n_take_a;
    logic          n_w0_en, n_w1_en;
    logic [AW-1:0] n_w0_addr;
    logic signed [DATA_W-1:0] n_w0_data;
    logic          n_has_room;

    assign n_nw    = IW'(r_count);
    assign n_2w    = IW'(r_width) << 1;
    assign n_lo_w  = IW'(r_lo) + IW'(r_width);
    assign n_lo_2w = IW'(r_lo) + n_2w;
    assign n_mid   = (n_lo_w  > n_nw) ? r_count : n_lo_w[CW-1:0];
    assign n_hi    = (n_lo_2w > n_nw) ? r_count : n_lo_2w[CW-1:0];

    assign n_has_room = (r_count < CW'(DEPTH));

    // current source store, data registered from the previous cycle
    assign n_qa = r_src ? r_q10 : r_q00;
    assign n_qb = r_src ? r_q11 : r_q01;

    // ties go to the right run
    assign n_take_a = (r_a < r_mid) && ((r_b >= r_hi) || (n_qa < n_qb));
    assign n_merged = n_take_a ? n_qa : n_qb;

    always_comb begin
        n_w0_en   = 1'b0;
        n_w0_addr = r_k[AW-1:0];
        n_w0_data = n_merged;
        if (i_cmd.load && n_has_room) begin
            n_w0_en   = 1'b1;
            n_w0_addr = r_count[AW-1:0];
            n_w0_data = i_value;
        end else if (i_cmd.step && r_src) begin
            n_w0_en = 1'b1;
        end
    end

    assign n_w1_en = i_cmd.step && !r_src;

    always_ff @(posedge i_clk) begin
        if (n_w0_en) begin
            r_mem0[n_w0_addr] <= n_w0_data;
        end
        r_q00 <= r_mem0[r_a[AW-1:0]];
        r_q01 <= r_mem0[r_b[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (n_w1_en) begin
            r_mem1[r_k[AW-1:0]] <= n_merged;
        end
        r_q10 <= r_mem1[r_a[AW-1:0]];
        r_q11 <= r_mem1[r_b[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_src   <= 1'b0;
        end else begin
            priority if (i_cmd.clear) begin
                r_count <= '0;
            end else if (i_cmd.load && n_has_room) begin
                r_count <= r_count + CW'(1);
            end
            priority if (i_cmd.sort_init) begin
                r_src <= 1'b0;
            end else if (i_cmd.next_pass) begin
                r_src <= ~r_src;
            end
        end
    end

    // run bounds and pass width
    always_ff @(posedge i_clk) begin
        priority if (i_cmd.sort_init) begin
            r_width <= CW'(1);
            r_lo    <= '0;
        end else if (i_cmd.next_pass) begin
            r_width <= n_2w[CW-1:0];
            r_lo    <= '0;
        end else if (i_cmd.next_run) begin
            r_lo    <= n_lo_2w[CW-1:0];
        end
        if (i_cmd.run_init) begin
            r_mid <= n_mid;
            r_hi  <= n_hi;
        end
    end

    // merge and output pointers
    always_ff @(posedge i_clk) begin
        priority if (i_cmd.run_init) begin
            r_a <= r_lo;
            r_b <= n_mid;
            r_k <= r_lo;
        end else if (i_cmd.step) begin
            if (n_take_a) begin
                r_a <= r_a + CW'(1);
            end else begin
                r_b <= r_b + CW'(1);
            end
            r_k <= r_k + CW'(1);
        end else if (i_cmd.emit_init) begin
            r_a <= '0;
        end else if (i_cmd.emit_adv) begin
            r_a <= r_a + CW'(1);
        end
    end

    assign o_stat.n_gt1     = (r_count > CW'(1));
    assign o_stat.run_last  = ((r_k + CW'(1)) == r_hi);
    assign o_stat.pass_last = (r_hi == r_count);
    assign o_stat.sort_last = (n_2w >= n_nw);
    assign o_stat.emit_last = ((r_a + CW'(1)) == r_count);

    assign o_sorted_value = n_qa;
    assign o_final_res    = i_cmd.emit_adv && o_stat.emit_last;

    a_step_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_k < r_hi) && ((r_a < r_mid) || (r_b < r_hi)))
        else $error("merge step outside its run");

    a_emit_in_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_adv |-> (r_a < r_count))
        else $error("emit pointer past element count");

endmodule

### hdl/ms_ctrl.sv
// Merge sorter controller: sequences load, merge passes and output.
// Drives datapath commands from its status. Depends on ms_pkg.
`timescale 1ns / 1ps

module ms_ctrl import ms_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  logic     i_last,
    output logic     busy,
    output logic     o_strobe,
    output t_ms_cmd  o_cmd,
    input  t_ms_stat i_stat
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_SETUP     = 3'd1;
    localparam logic [2:0] S_RUN_INIT  = 3'd2;
    localparam logic [2:0] S_RD        = 3'd3;
    localparam logic [2:0] S_WR        = 3'd4;
    localparam logic [2:0] S_EMIT_INIT = 3'd5;
    localparam logic [2:0] S_EMIT_RD   = 3'd6;
    localparam logic [2:0] S_EMIT_OUT  = 3'd7;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state  = r_state;
        o_cmd    = '0;
        o_strobe = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    if (i_last) begin
                        n_state = S_SETUP;
                    end
                end
            end
            S_SETUP: begin
                o_cmd.sort_init = 1'b1;
                n_state = i_stat.n_gt1 ? S_RUN_INIT : S_EMIT_INIT;
            end
            S_RUN_INIT: begin
                o_cmd.run_init = 1'b1;
                n_state = S_RD;
            end
            S_RD: begin
                // wait for registered store data
                n_state = S_WR;
            end
            S_WR: begin
                o_cmd.step = 1'b1;
                n_state = S_RD;
                if (i_stat.run_last) begin
                    n_state = S_RUN_INIT;
                    if (i_stat.pass_last) begin
                        o_cmd.next_pass = 1'b1;
                        if (i_stat.sort_last) begin
                            n_state = S_EMIT_INIT;
                        end
                    end else begin
                        o_cmd.next_run = 1'b1;
                    end
                end
            end
            S_EMIT_INIT: begin
                o_cmd.emit_init = 1'b1;
                n_state = S_EMIT_RD;
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_OUT;
            end
            S_EMIT_OUT: begin
                o_cmd.emit_adv = 1'b1;
                o_strobe = 1'b1;
                n_state = S_EMIT_RD;
                if (i_stat.emit_last) begin
                    o_cmd.clear = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### hdl/merge_sorter.sv
// Bottom-up merge sorter. Load: one element per start while idle. Closing set
// (n held): a setup step, then per pass (ceil(log2 n) passes) a run setup per
// run pair, a read and a write state per element; then per element a read and
// an output state, one strobe each. Merge rate is set by the registered read of
// the element stores. Synchronous active-low reset returns to idle with an empty
// set; results cannot be stalled. Instantiates ms_ctrl and ms_dp, uses ms_pkg.
`timescale 1ns / 1ps

module merge_sorter import ms_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic                     i_last,
    output logic                     o_strobe,
    output logic signed [DATA_W-1:0] o_sorted_value,
    output logic                     o_final_res
);

    t_ms_cmd  w_cmd;
    t_ms_stat w_stat;

    ms_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_last   (i_last),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_cmd    (w_cmd),
        .i_stat   (w_stat)
    );

    ms_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_value        (i_value),
        .o_sorted_value (o_sorted_value),
        .o_final_res    (o_final_res)
    );

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result transfer while idle");

    a_final_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_final_res) |=> !busy)
        else $error("still busy after final result");

    a_close_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_last) |=> busy)
        else $error("closing transfer did not start a sort");

endmodule
